@@ design/tcf_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants for the two-class oldest-first FIFO.
package tcf_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int PAYLOAD_W   = 32;
    localparam int STAMP_W     = 6;
    localparam int ADDR_W      = $clog2(QUEUE_DEPTH);
    localparam int COUNT_W     = ADDR_W + 1;

    typedef enum logic [1:0] {
        OP_ENQ    = 2'd0,
        OP_ANY    = 2'd1,
        OP_FIRST  = 2'd2,
        OP_SECOND = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        STS_OK    = 2'd0,
        STS_EMPTY = 2'd1,
        STS_FULL  = 2'd2
    } t_status;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_EXEC = 1'b1
    } t_state;

    typedef struct packed {
        t_op                  op;
        logic                 kind;
        logic [PAYLOAD_W-1:0] payload;
    } t_in_beat;

    typedef struct packed {
        logic                 item_valid;
        logic                 item_kind;
        logic [PAYLOAD_W-1:0] item_payload;
        t_status              status;
        logic                 first_empty;
        logic                 second_empty;
    } t_out_beat;

    typedef struct packed {
        logic [PAYLOAD_W-1:0] payload;
        logic [STAMP_W-1:0]   stamp;
    } t_entry;

    typedef struct packed {
        logic empty;
        logic full;
        logic last;
    } t_q_status;

    typedef struct packed {
        logic load;
        logic commit;
    } t_dp_cmd;

    typedef struct packed {
        logic out_free;
    } t_dp_status;

endpackage

@@ design/tcf_queue.sv @@
`timescale 1ns / 1ps
// One class queue: circular store with head pointer, fill count and registered head read.
module tcf_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_load,
    input  logic               i_push,
    input  logic               i_pop,
    input  tcf_pkg::t_entry    i_wdata,
    output tcf_pkg::t_entry    o_rd,
    output tcf_pkg::t_q_status o_status
);

    localparam logic [tcf_pkg::COUNT_W-1:0] DEPTH_C = tcf_pkg::COUNT_W'(tcf_pkg::QUEUE_DEPTH);
    localparam logic [tcf_pkg::ADDR_W-1:0]  LAST_C  = tcf_pkg::ADDR_W'(tcf_pkg::QUEUE_DEPTH - 1);

    tcf_pkg::t_entry               r_mem [tcf_pkg::QUEUE_DEPTH];
    tcf_pkg::t_entry               r_rd;
    logic [tcf_pkg::ADDR_W-1:0]    r_head;
    logic [tcf_pkg::ADDR_W-1:0]    n_head;
    logic [tcf_pkg::COUNT_W-1:0]   r_count;
    logic [tcf_pkg::COUNT_W-1:0]   n_count;
    logic [tcf_pkg::COUNT_W-1:0]   tail_sum;
    logic [tcf_pkg::ADDR_W-1:0]    tail;

    always_comb begin
        tail_sum = {1'b0, r_head} + r_count;
        if (tail_sum >= DEPTH_C) begin
            tail_sum = tail_sum - DEPTH_C;
        end
        tail = tail_sum[tcf_pkg::ADDR_W-1:0];

        n_head  = r_head;
        n_count = r_count;
        if (i_push) begin
            n_count = r_count + 1'b1;
        end else if (i_pop) begin
            n_count = r_count - 1'b1;
            n_head  = (r_head == LAST_C) ? '0 : r_head + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[tail] <= i_wdata;
        end
        if (i_load) begin
            r_rd <= r_mem[r_head];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_count <= '0;
        end else begin
            r_head  <= n_head;
            r_count <= n_count;
        end
    end

    assign o_rd           = r_rd;
    assign o_status.empty = (r_count == '0);
    assign o_status.full  = (r_count == DEPTH_C);
    assign o_status.last  = (r_count == tcf_pkg::COUNT_W'(1));

endmodule

@@ design/tcf_dp.sv @@
`timescale 1ns / 1ps
// Datapath: item registers, both class queues, stamp counter, oldest-head select, result register.
module tcf_dp (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  tcf_pkg::t_dp_cmd    i_cmd,
    output tcf_pkg::t_dp_status o_status,
    input  tcf_pkg::t_in_beat   i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output tcf_pkg::t_out_beat  o_out_data
);

    tcf_pkg::t_op                   r_op;
    logic                           r_kind;
    logic [tcf_pkg::PAYLOAD_W-1:0]  r_payload;
    logic [tcf_pkg::STAMP_W-1:0]    r_stamp;
    logic                           r_out_valid;
    tcf_pkg::t_out_beat             r_out;
    tcf_pkg::t_out_beat             n_out;

    tcf_pkg::t_entry    f_rd;
    tcf_pkg::t_entry    s_rd;
    tcf_pkg::t_entry    wdata;
    tcf_pkg::t_q_status f_st;
    tcf_pkg::t_q_status s_st;
    tcf_pkg::t_status   n_sts;

    logic [tcf_pkg::STAMP_W-1:0] stamp_diff;
    logic push_first;
    logic push_second;
    logic take;
    logic take_second;
    logic pop_first;
    logic pop_second;

    assign wdata = '{payload: r_payload, stamp: r_stamp};

    tcf_queue u_first (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (i_cmd.load),
        .i_push   (i_cmd.commit && push_first),
        .i_pop    (i_cmd.commit && pop_first),
        .i_wdata  (wdata),
        .o_rd     (f_rd),
        .o_status (f_st)
    );

    tcf_queue u_second (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (i_cmd.load),
        .i_push   (i_cmd.commit && push_second),
        .i_pop    (i_cmd.commit && pop_second),
        .i_wdata  (wdata),
        .o_rd     (s_rd),
        .o_status (s_st)
    );

    always_comb begin
        stamp_diff  = f_rd.stamp - s_rd.stamp;
        push_first  = 1'b0;
        push_second = 1'b0;
        take        = 1'b0;
        take_second = 1'b0;
        n_sts       = tcf_pkg::STS_OK;
        case (r_op)
            tcf_pkg::OP_ENQ: begin
                if (r_kind ? s_st.full : f_st.full) begin
                    n_sts = tcf_pkg::STS_FULL;
                end else begin
                    push_first  = !r_kind;
                    push_second = r_kind;
                end
            end
            tcf_pkg::OP_ANY: begin
                if (f_st.empty && s_st.empty) begin
                    n_sts = tcf_pkg::STS_EMPTY;
                end else if (s_st.empty) begin
                    take = 1'b1;
                end else if (f_st.empty) begin
                    take        = 1'b1;
                    take_second = 1'b1;
                end else begin
                    take        = 1'b1;
                    take_second = !stamp_diff[tcf_pkg::STAMP_W-1];
                end
            end
            tcf_pkg::OP_FIRST: begin
                if (f_st.empty) begin
                    n_sts = tcf_pkg::STS_EMPTY;
                end else begin
                    take = 1'b1;
                end
            end
            tcf_pkg::OP_SECOND: begin
                if (s_st.empty) begin
                    n_sts = tcf_pkg::STS_EMPTY;
                end else begin
                    take        = 1'b1;
                    take_second = 1'b1;
                end
            end
            default: begin
                n_sts = tcf_pkg::STS_OK;
            end
        endcase
        pop_first  = take && !take_second;
        pop_second = take && take_second;

        n_out.item_valid   = take;
        n_out.item_kind    = take_second;
        n_out.item_payload = take ? (take_second ? s_rd.payload : f_rd.payload) : '0;
        n_out.status       = n_sts;
        n_out.first_empty  = push_first ? 1'b0 : (pop_first ? f_st.last : f_st.empty);
        n_out.second_empty = push_second ? 1'b0 : (pop_second ? s_st.last : s_st.empty);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op      <= i_in_data.op;
            r_kind    <= i_in_data.kind;
            r_payload <= i_in_data.payload;
        end
        if (i_cmd.commit) begin
            r_out <= n_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stamp     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.commit && (push_first || push_second)) begin
                r_stamp <= r_stamp + 1'b1;
            end
            if (i_cmd.commit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_status.out_free = !r_out_valid || i_out_ready;
    assign o_out_valid       = r_out_valid;
    assign o_out_data        = r_out;

endmodule

@@ design/tcf_ctrl.sv @@
`timescale 1ns / 1ps
// Controller: accepts one beat, then commits it once the result register is free.
module tcf_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  tcf_pkg::t_dp_status i_status,
    output tcf_pkg::t_dp_cmd    o_cmd
);

    tcf_pkg::t_state r_state;
    tcf_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tcf_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state      = r_state;
        o_in_ready   = 1'b0;
        o_cmd.load   = 1'b0;
        o_cmd.commit = 1'b0;
        case (r_state)
            tcf_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = tcf_pkg::ST_EXEC;
                end
            end
            tcf_pkg::ST_EXEC: begin
                if (i_status.out_free) begin
                    o_cmd.commit = 1'b1;
                    n_state      = tcf_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = tcf_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

@@ design/two_class_fifo_oldest_first_top.sv @@
`timescale 1ns / 1ps
// Top level of the two-class FIFO with oldest-first dequeue.
//
// Input channel (i_in_valid / o_in_ready / i_in_data) carries one operation per
// beat: enqueue into a class, dequeue the oldest head of either class, or dequeue
// the head of a named class. Output channel (o_out_valid / i_out_ready /
// o_out_data) returns exactly one result beat per operation: the dequeued item if
// any, a status code (ok, dequeue from empty, enqueue into full) and whether each
// queue is empty afterwards.
// Each queue holds 16 entries; each entry keeps the payload and a 6-bit arrival
// stamp taken from a counter shared by both classes.
// An accepted beat loads the item registers and the registered head read of each
// queue; the execute state then selects and commits the result. A new beat is not
// accepted until the previous one has been committed.
// The result register frees the input side: a new beat is accepted while the
// previous result waits; when the receiver stalls, the next beat is held in the
// item registers and the input stays not ready until the result register drains.
// Reset clears the state machine, queue pointers and counts, the stamp counter
// and the output valid flag; queue contents need no clearing.
module two_class_fifo_oldest_first_top (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  tcf_pkg::t_in_beat  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output tcf_pkg::t_out_beat o_out_data
);

    tcf_pkg::t_dp_cmd    cmd;
    tcf_pkg::t_dp_status dp_status;

    tcf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_status   (dp_status),
        .o_cmd      (cmd)
    );

    tcf_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_status    (dp_status),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("input accepted while previous beat still in progress");

    a_item_means_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.item_valid) |-> (o_out_data.status == tcf_pkg::STS_OK))
        else $error("dequeued item reported with error status");

    a_full_not_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.status == tcf_pkg::STS_FULL)
            |-> (!o_out_data.first_empty || !o_out_data.second_empty))
        else $error("full status reported while both queues empty");

endmodule
